// ===== design/bsum_pkg.sv =====
`default_nettype none

package bsum_pkg;

  // Sizes of the grid and of the data path
  localparam int MAX_DIM    = 128;
  localparam int VALUE_BITS = 8;
  localparam int DIM_BITS   = 8;
  localparam int ROW_BITS   = DIM_BITS;
  localparam int COL_BITS   = $clog2(MAX_DIM);
  localparam int POS_BITS   = 7;
  localparam int CSUM_BITS  = VALUE_BITS + 2;
  localparam int SUM_BITS   = 12;
  localparam int WIN_TAPS   = 2;

  // Configuration register indexes
  localparam int IDX_BITS = 1;
  localparam logic [IDX_BITS-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [IDX_BITS-1:0] REG_GRID_COLS = 1'b1;

  typedef logic [VALUE_BITS-1:0] bsum_val_t;
  typedef logic [DIM_BITS-1:0]   bsum_dim_t;
  typedef logic [CSUM_BITS-1:0]  bsum_csum_t;

  // Line store write request
  typedef struct packed {
    logic                en;
    logic [COL_BITS-1:0] addr;
    bsum_val_t           upper;
    bsum_val_t           middle;
  } bsum_wr_t;

  // Item held in the window stage
  typedef struct packed {
    bsum_val_t           value;
    logic [COL_BITS-1:0] col;
    logic                first_col;
    logic                active;
    logic                top_en;
    logic                mid_en;
    logic                bot_en;
    logic                emit_a;
    logic                emit_b;
    logic                last;
    logic [POS_BITS-1:0] erow;
    logic [POS_BITS-1:0] ecol;
  } bsum_s1_t;

  // Map a size of zero to one and an oversize to the maximum
  function automatic bsum_dim_t clamp_dim(input bsum_dim_t v);
    bsum_dim_t r;
    if (v == '0) begin
      r = bsum_dim_t'(1);
    end else if (v > bsum_dim_t'(MAX_DIM)) begin
      r = bsum_dim_t'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/bsum_stream_if.sv =====
`default_nettype none

interface bsum_in_if import bsum_pkg::*; ();
  logic      valid;
  logic      ready;
  bsum_val_t cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

interface bsum_out_if import bsum_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SUM_BITS-1:0] neighbor_sum;
  logic [POS_BITS-1:0] out_row;
  logic [POS_BITS-1:0] out_col;
  logic                last_of_grid;

  modport source (output valid, output neighbor_sum, output out_row, output out_col,
                  output last_of_grid, input ready);
  modport sink   (input valid, input neighbor_sum, input out_row, input out_col,
                  input last_of_grid, output ready);
endinterface

`default_nettype wire

// ===== design/box_sum_3x3_zero_padded.sv =====
// 3x3 box sum with zero padding over a raster-order grid.
// Channels: cells (sink) takes cell_value in raster order, sums (source) gives
// neighbor_sum with out_row, out_col and last_of_grid. Both use valid/ready; a
// transfer happens at a rising edge with valid and ready high.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 grid_rows,
// 1 grid_cols); sizes of zero act as one and sizes above 128 as 128. Write
// only while the block is idle.
// The sum for a cell is caused by the item grid_cols+1 positions later, so
// after the last cell send grid_cols+1 drain items (values ignored); the last
// of them carries last_of_grid and the position counters then restart.
// A result goes through the window stage and result registers. Throughput:
// one item per cycle unless sums stalls, set by one line-store read and one
// write per cycle on the two column stages and the window cells.
// Reset (rst, synchronous): position counters and window to zero, both sizes
// to one, pipeline empty. The line stores are not cleared; every column is
// written before it is read.
// A stalled receiver holds the result register and the whole pipeline; cells
// is refused until sums moves on.
`default_nettype none

module box_sum_3x3_zero_padded import bsum_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [IDX_BITS-1:0] cfg_index,
  input  wire bsum_dim_t           cfg_data,
  bsum_in_if.sink                  cells,
  bsum_out_if.source               sums
);

  bsum_dim_t            grid_rows;
  bsum_dim_t            grid_cols;
  logic [ROW_BITS-1:0]  in_row;
  logic [COL_BITS-1:0]  in_col;
  logic [ROW_BITS-1:0]  in_row_next;
  logic [COL_BITS-1:0]  in_col_next;

  logic                 en;
  logic                 accept;
  logic                 commit;

  bsum_dim_t            rows_c;
  bsum_dim_t            cols_c;
  bsum_dim_t            drain_row;
  logic [ROW_BITS-1:0]  r;
  logic [COL_BITS-1:0]  c;
  bsum_dim_t            c_inc;
  bsum_s1_t             s0;

  logic                 s1_valid;
  bsum_s1_t             s1;

  bsum_val_t            rd_upper;
  bsum_val_t            rd_middle;
  bsum_wr_t             wr;
  bsum_val_t            top;
  bsum_val_t            mid;
  bsum_val_t            bot;
  bsum_csum_t           new_col;
  bsum_csum_t           col_sum [WIN_TAPS];
  logic [SUM_BITS-1:0]  sum;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= bsum_dim_t'(1);
      grid_cols <= bsum_dim_t'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_ROWS: grid_rows <= cfg_data;
        REG_GRID_COLS: grid_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline moves whenever the result register is free or being taken
  assign en          = !sums.valid || sums.ready;
  assign cells.ready = en;
  assign accept      = en && cells.valid;
  assign commit      = en && s1_valid;

  // Position of the incoming item and what it causes
  always_comb begin
    rows_c    = clamp_dim(grid_rows);
    cols_c    = clamp_dim(grid_cols);
    drain_row = rows_c + bsum_dim_t'(1);
    if (bsum_dim_t'(in_col) >= cols_c) begin
      c = '0;
      r = in_row + ROW_BITS'(1);
    end else begin
      c = in_col;
      r = in_row;
    end
    if (r >= drain_row) begin
      r = drain_row;
      c = '0;
    end

    s0.value     = cells.cell_value;
    s0.col       = c;
    s0.first_col = (c == '0);
    s0.active    = (r <= rows_c);
    s0.top_en    = (r >= ROW_BITS'(2));
    s0.mid_en    = (r >= ROW_BITS'(1));
    s0.bot_en    = (r < rows_c);
    s0.emit_a    = (c == '0) && (r >= ROW_BITS'(2));
    s0.emit_b    = (c != '0) && (r >= ROW_BITS'(1)) && (r <= rows_c);
    s0.last      = (r == drain_row);
    if (s0.emit_a) begin
      s0.erow = POS_BITS'(r - ROW_BITS'(2));
      s0.ecol = POS_BITS'(cols_c - bsum_dim_t'(1));
    end else begin
      s0.erow = POS_BITS'(r - ROW_BITS'(1));
      s0.ecol = POS_BITS'(c - COL_BITS'(1));
    end

    c_inc = bsum_dim_t'(c) + bsum_dim_t'(1);
    if (r >= drain_row) begin
      in_row_next = '0;
      in_col_next = '0;
    end else if (c_inc >= cols_c) begin
      in_row_next = r + ROW_BITS'(1);
      in_col_next = '0;
    end else begin
      in_row_next = r;
      in_col_next = COL_BITS'(c_inc);
    end
  end

  // Advance the position counters on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_row <= '0;
      in_col <= '0;
    end else if (accept) begin
      in_row <= in_row_next;
      in_col <= in_col_next;
    end
  end

  // Window stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= cells.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s0;
    end
  end

  bsum_line_buf u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr   (c),
    .wr        (wr),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle)
  );

  // New column and the line-store update
  always_comb begin
    top     = s1.top_en ? rd_upper  : '0;
    mid     = s1.mid_en ? rd_middle : '0;
    bot     = s1.bot_en ? s1.value  : '0;
    new_col = CSUM_BITS'(top) + CSUM_BITS'(mid) + CSUM_BITS'(bot);

    wr.en     = commit && s1.active;
    wr.addr   = s1.col;
    wr.upper  = mid;
    wr.middle = bot;
  end

  // Row of window cells: the newest column enters the last cell
  for (genvar k = 0; k < WIN_TAPS; k++) begin : g_win
    if (k == WIN_TAPS - 1) begin : g_head
      bsum_col_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .adv     (commit),
        .clear   (!s1.active),
        .col_in  (new_col),
        .col_sum (col_sum[k])
      );
    end else begin : g_body
      bsum_col_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .adv     (commit),
        .clear   (s1.first_col),
        .col_in  (col_sum[k+1]),
        .col_sum (col_sum[k])
      );
    end
  end

  // Two held columns plus the new one; a row end closes with a zero column
  always_comb begin
    sum = SUM_BITS'(col_sum[0]) + SUM_BITS'(col_sum[1]);
    if (s1.emit_b) begin
      sum = sum + SUM_BITS'(new_col);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      sums.valid <= 1'b0;
    end else if (en) begin
      sums.valid <= s1_valid && (s1.emit_a || s1.emit_b);
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      sums.neighbor_sum <= sum;
      sums.out_row      <= s1.erow;
      sums.out_col      <= s1.ecol;
      sums.last_of_grid <= s1.emit_a && s1.last;
    end
  end

endmodule

`default_nettype wire

// ===== design/bsum_line_buf.sv =====
`default_nettype none

module bsum_line_buf import bsum_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                rd_en,
  input  wire logic [COL_BITS-1:0] rd_addr,
  input  wire bsum_wr_t            wr,
  output      bsum_val_t           rd_upper,
  output      bsum_val_t           rd_middle
);

  bsum_val_t upper_line  [MAX_DIM];
  bsum_val_t middle_line [MAX_DIM];

  bsum_val_t upper_q;
  bsum_val_t middle_q;
  logic      fwd;
  bsum_val_t fwd_upper;
  bsum_val_t fwd_middle;

  // Write both line stores at one column
  always_ff @(posedge clk) begin
    if (wr.en) begin
      upper_line[wr.addr]  <= wr.upper;
      middle_line[wr.addr] <= wr.middle;
    end
  end

  // Read both line stores; hold the data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      upper_q  <= upper_line[rd_addr];
      middle_q <= middle_line[rd_addr];
    end
  end

  // Capture a write to the column being read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (rd_en) begin
      fwd <= wr.en && (wr.addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_upper  <= wr.upper;
      fwd_middle <= wr.middle;
    end
  end

  assign rd_upper  = fwd ? fwd_upper  : upper_q;
  assign rd_middle = fwd ? fwd_middle : middle_q;

endmodule

`default_nettype wire

// ===== design/bsum_col_cell.sv =====
`default_nettype none

module bsum_col_cell import bsum_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       adv,
  input  wire logic       clear,
  input  wire bsum_csum_t col_in,
  output      bsum_csum_t col_sum
);

  // Take the incoming column sum (the neighbour's, or the new one), or zero on clear
  always_ff @(posedge clk) begin
    if (rst) begin
      col_sum <= '0;
    end else if (adv) begin
      col_sum <= clear ? '0 : col_in;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
  import bsum_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 160;
  localparam int MAX_GAP       = 18;
  localparam int RANDOM_CELLS  = 1200;
  localparam int HOLD_GRID     = 4;
  localparam int SCRIPT_LEN    = 31;

  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
    logic                last;
  } box_result_t;

  typedef enum logic {STEP_CFG, STEP_CELL} step_kind_t;

  typedef struct packed {
    step_kind_t          kind;
    logic [IDX_BITS-1:0] reg_index;
    bsum_val_t           data;
    logic                typed;
    box_result_t         want;
  } script_step_t;

  // Directed opening: a 3x3 grid of full-scale cells with full-scale drain items,
  // a zero-size grid, then a 3x4 grid whose sizes shrink part way through.
  localparam script_step_t SCRIPT [SCRIPT_LEN] = '{
    '{STEP_CFG,  REG_GRID_ROWS, 8'd3,   1'b0, '0},
    '{STEP_CFG,  REG_GRID_COLS, 8'd3,   1'b0, '0},
    '{STEP_CELL, REG_GRID_ROWS, 8'hFF,  1'b0, '0},
    '{STEP_CELL, REG_GRID_ROWS, 8'hFF,  1'b0, '0},
    '{STEP_CELL, REG_GRID_ROWS, 8'hFF,  1'b0, '0},
    '{STEP_CELL, REG_GRID_ROWS, 8'hFF,  1'b0, '0},
    '{STEP_CELL, REG_GRID_ROWS, 8'hFF,  1'b1, '{12'd1020, 7'd0, 7'd0, 1'b0}},
    '{STEP_CELL, REG_GRID_ROWS, 8'hFF,  1'b1, '{12'd1530, 7'd0, 7'd1, 1'b0}},
    '{STEP_CELL, REG_GRID_ROWS, 8'hFF,  1'b1, '{12'd1020, 7'd0, 7'd2, 1'b0}},
    '{STEP_CELL, REG_GRID_ROWS, 8'hFF,  1'b1, '{12'd1530, 7'd1, 7'd0, 1'b0}},
    '{STEP_CELL, REG_GRID_ROWS, 8'hFF,  1'b1, '{12'd2295, 7'd1, 7'd1, 1'b0}},
    '{STEP_CELL, REG_GRID_ROWS, 8'hFF,  1'b1, '{12'd1530, 7'd1, 7'd2, 1'b0}},
    '{STEP_CELL, REG_GRID_ROWS, 8'hFF,  1'b1, '{12'd1020, 7'd2, 7'd0, 1'b0}},
    '{STEP_CELL, REG_GRID_ROWS, 8'hFF,  1'b1, '{12'd1530, 7'd2, 7'd1, 1'b0}},
    '{STEP_CELL, REG_GRID_ROWS, 8'hFF,  1'b1, '{12'd1020, 7'd2, 7'd2, 1'b1}},
    '{STEP_CFG,  REG_GRID_ROWS, 8'd0,   1'b0, '0},
    '{STEP_CFG,  REG_GRID_COLS, 8'd0,   1'b0, '0},
    '{STEP_CELL, REG_GRID_ROWS, 8'h5A,  1'b0, '0},
    '{STEP_CELL, REG_GRID_ROWS, 8'hFF,  1'b0, '0},
    '{STEP_CELL, REG_GRID_ROWS, 8'h00,  1'b1, '{12'd90, 7'd0, 7'd0, 1'b1}},
    '{STEP_CFG,  REG_GRID_ROWS, 8'd3,   1'b0, '0},
    '{STEP_CFG,  REG_GRID_COLS, 8'd4,   1'b0, '0},
    '{STEP_CELL, REG_GRID_ROWS, 8'h01,  1'b0, '0},
    '{STEP_CELL, REG_GRID_ROWS, 8'h80,  1'b0, '0},
    '{STEP_CELL, REG_GRID_ROWS, 8'h7F,  1'b0, '0},
    '{STEP_CELL, REG_GRID_ROWS, 8'hFE,  1'b0, '0},
    '{STEP_CELL, REG_GRID_ROWS, 8'h00,  1'b0, '0},
    '{STEP_CFG,  REG_GRID_COLS, 8'd1,   1'b0, '0},
    '{STEP_CELL, REG_GRID_ROWS, 8'hC3,  1'b0, '0},
    '{STEP_CFG,  REG_GRID_ROWS, 8'd1,   1'b0, '0},
    '{STEP_CELL, REG_GRID_ROWS, 8'h3C,  1'b0, '0}
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [IDX_BITS-1:0] cfg_index;
  bsum_dim_t           cfg_data;

  bsum_in_if  cells_if ();
  bsum_out_if sums_if ();

  // Box-sum predictor state
  bsum_dim_t   rows_reg;
  bsum_dim_t   cols_reg;
  bsum_val_t   upper_mem [MAX_DIM];
  bsum_val_t   middle_mem [MAX_DIM];
  bsum_val_t   win [3][3];
  int unsigned at_row;
  int unsigned at_col;
  box_result_t sums_due [$];

  int  mismatches;
  int  cells_sent;
  int  sums_checked;
  int  size_writes;
  int  grids_done;
  int  reshapes;
  int  holds_done;
  bit  hold_off_req;

  box_sum_3x3_zero_padded dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cells     (cells_if),
    .sums      (sums_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned eff_dim(input bsum_dim_t v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  // Shift one new column into the window; column 0 is the oldest
  function automatic void slide_window(input bsum_val_t top, input bsum_val_t mid,
                                       input bsum_val_t bot);
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = bot;
  endfunction

  function automatic box_result_t window_total(input int unsigned r, input int unsigned c,
                                               input logic last);
    box_result_t res;
    int unsigned acc;
    acc = 0;
    foreach (win[i, j]) acc += 32'(win[i][j]);
    res.sum  = acc[SUM_BITS-1:0];
    res.row  = r[POS_BITS-1:0];
    res.col  = c[POS_BITS-1:0];
    res.last = last;
    return res;
  endfunction

  // Take one cell in raster order; return 1 when it completes a neighbourhood sum
  function automatic logic predict_cell(input bsum_val_t v, output box_result_t res);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    bsum_val_t   top;
    bsum_val_t   mid;
    bsum_val_t   bot;
    logic        got;
    rows = eff_dim(rows_reg);
    cols = eff_dim(cols_reg);
    got  = 1'b0;
    res  = '0;
    // sizes may have shrunk since the last cell: wrap or jump to the final drain item
    if (at_col >= cols) begin
      at_col = 0;
      at_row++;
    end
    if (at_row >= rows + 1) begin
      at_row = rows + 1;
      at_col = 0;
    end
    r = at_row;
    c = at_col;
    // first column: close off the previous row's last cell, then pad the left edge
    if (c == 0) begin
      if (r >= 2) begin
        slide_window('0, '0, '0);
        res = window_total(r - 2, cols - 1, r == rows + 1);
        got = 1'b1;
      end
      foreach (win[i, j]) win[i][j] = '0;
    end
    // grid rows and the drain row move the line stores along
    if (r <= rows) begin
      top = (r >= 2) ? upper_mem[c] : '0;
      mid = (r >= 1) ? middle_mem[c] : '0;
      bot = (r < rows) ? v : '0;
      upper_mem[c]  = mid;
      middle_mem[c] = bot;
      slide_window(top, mid, bot);
      if (c > 0 && r >= 1) begin
        res = window_total(r - 1, c - 1, 1'b0);
        got = 1'b1;
      end
    end
    // advance, or restart after the final drain item
    if (r >= rows + 1) begin
      at_row = 0;
      at_col = 0;
    end else begin
      at_col++;
      if (at_col >= cols) begin
        at_col = 0;
        at_row++;
      end
    end
    return got;
  endfunction

  function automatic int draw_gap(input int pace);
    if (pace == 0) return 0;
    return ($urandom_range(0, pace - 1) == 0) ? int'($urandom_range(0, MAX_GAP)) : 0;
  endfunction

  function automatic bsum_dim_t pick_size();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return '0;
    if (k == 1) return bsum_dim_t'(1);
    if (k == 2) return bsum_dim_t'($urandom_range(10, 16));
    return bsum_dim_t'($urandom_range(2, 7));
  endfunction

  function automatic bsum_val_t pick_value();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return '0;
    if (k == 1) return '1;
    return bsum_val_t'($urandom_range(0, 255));
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Offer one cell after a gap, hold until the transfer, then book its result
  task automatic offer_cell(input bsum_val_t v, input int gap, input logic typed,
                            input box_result_t want);
    box_result_t res;
    logic        got;
    if (gap > 0) begin
      cells_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cells_if.valid      <= 1'b1;
    cells_if.cell_value <= v;
    do @(posedge clk); while (!cells_if.ready);
    got = predict_cell(v, res);
    if (typed) begin
      sums_due.push_back(want);
    end else if (got) begin
      sums_due.push_back(res);
    end
    cells_sent++;
  endtask

  // Write a size register once every pending sum is out and the pipe has settled
  task automatic write_size(input logic [IDX_BITS-1:0] idx, input bsum_dim_t val);
    cells_if.valid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GRID_ROWS) begin
      rows_reg = val;
    end else begin
      cols_reg = val;
    end
    size_writes++;
  endtask

  // Stimulus
  initial begin
    int        grid;
    int        pace;
    int        sent;
    int        random_cells;
    int        reshape_at;
    bit        reshape;
    bsum_dim_t nr;
    bsum_dim_t nc;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_GRID_ROWS;
    cfg_data            <= '0;
    cells_if.valid      <= 1'b0;
    cells_if.cell_value <= '0;
    rows_reg = bsum_dim_t'(1);
    cols_reg = bsum_dim_t'(1);
    at_row   = 0;
    at_col   = 0;
    foreach (win[i, j]) win[i][j] = '0;
    foreach (upper_mem[i]) begin
      upper_mem[i]  = '0;
      middle_mem[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // walk the directed table
    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == STEP_CFG) begin
        write_size(SCRIPT[i].reg_index, SCRIPT[i].data);
      end else begin
        offer_cell(SCRIPT[i].data, $urandom_range(0, MAX_GAP), SCRIPT[i].typed,
                   SCRIPT[i].want);
      end
    end

    // random grids: the size limits first, then mostly small ones
    grid         = 0;
    random_cells = 0;
    while (random_cells < RANDOM_CELLS) begin
      case (grid)
        0:         begin nr = bsum_dim_t'(128); nc = bsum_dim_t'(1);   end
        1:         begin nr = bsum_dim_t'(1);   nc = bsum_dim_t'(255); end
        2:         begin nr = bsum_dim_t'(255); nc = bsum_dim_t'(1);   end
        HOLD_GRID: begin nr = bsum_dim_t'(6);   nc = bsum_dim_t'(8);   end
        default:   begin nr = pick_size();      nc = pick_size();      end
      endcase
      write_size(REG_GRID_ROWS, nr);
      write_size(REG_GRID_COLS, nc);
      pace = $urandom_range(0, 3);
      if (grid == HOLD_GRID) begin
        pace         = 0;
        hold_off_req = 1'b1;
      end
      // every line-store column has been written once grid 1 is through,
      // so later grids may be resized part way
      reshape    = (grid > 2) && ($urandom_range(0, 7) == 0);
      reshape_at = $urandom_range(1, 20);
      sent       = 0;
      do begin
        if (reshape && sent == reshape_at) begin
          if ($urandom_range(0, 1) == 0) begin
            write_size(REG_GRID_ROWS, pick_size());
          end else begin
            write_size(REG_GRID_COLS, pick_size());
          end
          reshapes++;
        end
        offer_cell(pick_value(), draw_gap(pace), 1'b0, '0);
        sent++;
      end while (at_row != 0 || at_col != 0);
      random_cells += sent;
      grid++;
    end
    grids_done = grid;

    // drain and finish
    cells_if.valid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 4) @(posedge clk);
    $display("%0d random grids plus directed ones, %0d size writes, %0d cells in, %0d sums checked",
             grids_done, size_writes, cells_sent, sums_checked);
    $display("sizes 0, 1, 128 and 255 seen; %0d mid-grid resizes; %0d long output holds",
             reshapes, holds_done);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: random back-pressure, with one long hold-off on request
  initial begin
    int gap;
    int pace;
    int taken;
    sums_if.ready <= 1'b0;
    taken = 0;
    pace  = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (taken % 32 == 0) pace = $urandom_range(0, 3);
      if (hold_off_req) begin
        gap          = HOLD_CYCLES;
        hold_off_req = 1'b0;
        holds_done++;
      end else begin
        gap = draw_gap(pace);
      end
      if (gap > 0) begin
        sums_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      sums_if.ready <= 1'b1;
      do @(posedge clk); while (!(sums_if.valid && sums_if.ready));
      taken++;
    end
  end

  // Compare each transfer on the result side with the oldest pending sum
  always @(posedge clk) begin
    box_result_t want;
    if (!rst && sums_if.valid && sums_if.ready) begin
      if (sums_due.size() == 0) begin
        flag_mismatch($sformatf("sum %0d for (%0d,%0d) with nothing pending",
                                sums_if.neighbor_sum, sums_if.out_row, sums_if.out_col));
      end else begin
        want = sums_due.pop_front();
        if (sums_if.neighbor_sum !== want.sum)
          flag_mismatch($sformatf("neighbor_sum %0d, want %0d at (%0d,%0d)",
                                  sums_if.neighbor_sum, want.sum, want.row, want.col));
        if (sums_if.out_row !== want.row)
          flag_mismatch($sformatf("out_row %0d, want %0d", sums_if.out_row, want.row));
        if (sums_if.out_col !== want.col)
          flag_mismatch($sformatf("out_col %0d, want %0d", sums_if.out_col, want.col));
        if (sums_if.last_of_grid !== want.last)
          flag_mismatch($sformatf("last_of_grid %0b, want %0b at (%0d,%0d)",
                                  sums_if.last_of_grid, want.last, want.row, want.col));
      end
      sums_checked++;
    end
  end

  // Watchdog
  initial begin
    #1000000;
    $display("timed out with %0d sums pending", sums_due.size());
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
